### hw/rtl/plnsf_pkg.sv
// Shared types, field widths, register indexes and reset values for the
// power-law noise shaping filter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plnsf_pkg;

    localparam int DEFAULT_MAX_TAPS = 64;

    localparam int ALPHA_W   = 16;
    localparam int TAPS_W    = 7;
    localparam int WHITE_W   = 16;
    localparam int NOISE_W   = 24;
    localparam int COEF_W    = 18;
    localparam int RECIP_W   = 25;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [WHITE_W-1:0] white_t;
    typedef logic signed [NOISE_W-1:0] noise_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 2'd2;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd16384;
    localparam logic [TAPS_W-1:0]  TAPS_RESET  = 7'd16;
    localparam logic               BLUE_RESET  = 1'b0;

    // Leading coefficient, 1.0 in Q1.16.
    localparam coef_t COEF_ONE = 18'sd65536;
    localparam coef_t COEF_MAX = 18'sd131071;
    localparam coef_t COEF_MIN = -18'sd131072;

    localparam noise_t NOISE_MAX = 24'sd8388607;
    localparam noise_t NOISE_MIN = -24'sd8388608;

endpackage

`default_nettype wire

### hw/rtl/power_law_noise_shaping_filter.sv
// Power-law noise shaping filter, autoregressive form y = s - sum A[k]*y[t-k].
// Each beat runs taps_in_use - 1 multiply-accumulate steps through the
// coefficient and history memories at one tap per cycle, then drains the
// pipeline, rounds and outputs; items are processed one at a time. After
// reset and after every write to alpha_q14, taps_in_use or blue_mode the
// coefficients are recomputed one after another, and no input beat is
// taken meanwhile.
// A finished sample waits in an output register while the next beat is read.
// Depends on plnsf_pkg, plnsf_coef_gen and plnsf_filter.
`timescale 1ns / 1ps
`default_nettype none

module power_law_noise_shaping_filter #(
    parameter int MAX_TAPS = plnsf_pkg::DEFAULT_MAX_TAPS
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire [plnsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [plnsf_pkg::ALPHA_W-1:0]        cfg_data,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  plnsf_pkg::white_t                   s_white_sample,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output plnsf_pkg::noise_t                   m_noise_sample,
    output logic                                m_saturated
);

    localparam int AW  = $clog2(MAX_TAPS);
    localparam int TNW = $clog2(MAX_TAPS + 1);

    logic [plnsf_pkg::ALPHA_W-1:0]  alpha_reg;
    logic [plnsf_pkg::TAPS_W-1:0]   taps_reg;
    logic                           blue_reg;

    logic                           recompute;
    logic                           gen_busy;
    logic                           coef_we;
    logic [AW-1:0]                  coef_addr;
    plnsf_pkg::coef_t               coef_data;
    logic                           filt_idle;
    logic [TNW-1:0]                 taps_eff;
    logic [AW-1:0]                  last_k;

    assign cfg_ready = 1'b1;

    always_comb begin
        unique case (cfg_index)
            plnsf_pkg::REG_ALPHA: recompute = cfg_valid;
            plnsf_pkg::REG_TAPS:  recompute = cfg_valid;
            plnsf_pkg::REG_BLUE:  recompute = cfg_valid;
            default:              recompute = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= plnsf_pkg::ALPHA_RESET;
            taps_reg  <= plnsf_pkg::TAPS_RESET;
            blue_reg  <= plnsf_pkg::BLUE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                plnsf_pkg::REG_ALPHA: alpha_reg <= cfg_data;
                plnsf_pkg::REG_TAPS:  taps_reg  <= cfg_data[plnsf_pkg::TAPS_W-1:0];
                plnsf_pkg::REG_BLUE:  blue_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Depth out of range is clamped to 2..MAX_TAPS.
    always_comb begin
        if (32'(taps_reg) < 2) begin
            taps_eff = TNW'(2);
        end else if (32'(taps_reg) > MAX_TAPS) begin
            taps_eff = TNW'(MAX_TAPS);
        end else begin
            taps_eff = TNW'(taps_reg);
        end
        last_k = AW'(taps_eff - TNW'(1));
    end

    assign s_ready = filt_idle && !gen_busy && !cfg_valid;

    plnsf_coef_gen #(
        .MAX_TAPS (MAX_TAPS)
    ) u_coef_gen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (recompute),
        .alpha     (alpha_reg),
        .busy      (gen_busy),
        .coef_we   (coef_we),
        .coef_addr (coef_addr),
        .coef_data (coef_data)
    );

    plnsf_filter #(
        .MAX_TAPS (MAX_TAPS)
    ) u_filter (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (s_valid && s_ready),
        .white          (s_white_sample),
        .blue           (blue_reg),
        .last_k         (last_k),
        .coef_we        (coef_we),
        .coef_addr      (coef_addr),
        .coef_data      (coef_data),
        .idle           (filt_idle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_noise_sample (m_noise_sample),
        .m_saturated    (m_saturated)
    );

endmodule

`default_nettype wire

### hw/rtl/plnsf_coef_gen.sv
// Coefficient sequencer: computes A[1..MAX_TAPS-1] from alpha, two multiply
// steps per coefficient, and hands each result to the coefficient memory. Uses plnsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plnsf_coef_gen #(
    parameter int MAX_TAPS = plnsf_pkg::DEFAULT_MAX_TAPS
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 start,
    input  wire [plnsf_pkg::ALPHA_W-1:0]        alpha,
    output logic                                busy,
    output logic                                coef_we,
    output logic [$clog2(MAX_TAPS)-1:0]         coef_addr,
    output plnsf_pkg::coef_t                    coef_data
);

    localparam int AW   = $clog2(MAX_TAPS);
    localparam int FW   = AW + 17;
    localparam int P1W  = plnsf_pkg::COEF_W + FW;
    localparam int TW1  = P1W - 15;
    localparam int P2W  = TW1 + plnsf_pkg::RECIP_W + 1;
    localparam int UW   = P2W - 24;

    localparam logic [2:0] G_IDLE = 3'd0;
    localparam logic [2:0] G_MUL1 = 3'd1;
    localparam logic [2:0] G_RND1 = 3'd2;
    localparam logic [2:0] G_MUL2 = 3'd3;
    localparam logic [2:0] G_RND2 = 3'd4;

    localparam logic signed [P1W-1:0] HALF1 = P1W'(16384);
    localparam logic signed [P2W-1:0] HALF2 = P2W'(8388608);
    localparam logic signed [UW-1:0]  U_MAX = UW'(131071);
    localparam logic signed [UW-1:0]  U_MIN = -UW'(131072);

    // Reciprocals of k, round(2^24 / k), folded at elaboration.
    logic [plnsf_pkg::RECIP_W-1:0] recip_tab [MAX_TAPS];

    assign recip_tab[0] = '0;
    for (genvar g = 1; g < MAX_TAPS; g++) begin : g_recip
        localparam logic [plnsf_pkg::RECIP_W-1:0] RECIP =
            plnsf_pkg::RECIP_W'(((2 ** 24) + g / 2) / g);
        assign recip_tab[g] = RECIP;
    end

    logic [2:0]                     state_reg, state_next;
    logic [AW-1:0]                  k_reg, k_next;
    plnsf_pkg::coef_t               a_prev_reg, a_prev_next;
    logic signed [P1W-1:0]          prod1_reg;
    logic signed [TW1-1:0]          t_reg;
    logic signed [P2W-1:0]          prod2_reg;
    logic [plnsf_pkg::RECIP_W-1:0]  recip_reg;

    logic [AW+14:0]                 base;
    logic signed [FW-1:0]           factor;
    logic signed [P1W-1:0]          sum1;
    logic signed [P1W-1:0]          neg1;
    logic signed [P2W-1:0]          sum2;
    logic signed [P2W-1:0]          neg2;
    logic signed [UW-1:0]           u_val;
    plnsf_pkg::coef_t               a_sat;

    always_comb begin
        base   = {k_reg - AW'(1), 15'b0};
        factor = $signed({2'b00, base}) - $signed({{(FW - plnsf_pkg::ALPHA_W){1'b0}}, alpha});
        // Half away from zero: add half, less one for negative values, then shift.
        neg1   = P1W'(prod1_reg[P1W-1]);
        sum1   = prod1_reg + HALF1 - neg1;
        neg2   = P2W'(prod2_reg[P2W-1]);
        sum2   = prod2_reg + HALF2 - neg2;
        u_val  = sum2[P2W-1:24];
        if (u_val > U_MAX) begin
            a_sat = plnsf_pkg::COEF_MAX;
        end else if (u_val < U_MIN) begin
            a_sat = plnsf_pkg::COEF_MIN;
        end else begin
            a_sat = u_val[plnsf_pkg::COEF_W-1:0];
        end
    end

    always_comb begin
        state_next  = state_reg;
        k_next      = k_reg;
        a_prev_next = a_prev_reg;
        if (start) begin
            state_next  = G_MUL1;
            k_next      = AW'(1);
            a_prev_next = plnsf_pkg::COEF_ONE;
        end else begin
            unique case (state_reg)
                G_IDLE: state_next = G_IDLE;
                G_MUL1: state_next = G_RND1;
                G_RND1: state_next = G_MUL2;
                G_MUL2: state_next = G_RND2;
                G_RND2: begin
                    a_prev_next = a_sat;
                    if (k_reg == AW'(MAX_TAPS - 1)) begin
                        state_next = G_IDLE;
                    end else begin
                        k_next     = k_reg + AW'(1);
                        state_next = G_MUL1;
                    end
                end
                default: state_next = G_IDLE;
            endcase
        end
    end

    // After reset the sequencer runs at once, so the store holds the
    // coefficients of the reset alpha before the first beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= G_MUL1;
            k_reg      <= AW'(1);
            a_prev_reg <= plnsf_pkg::COEF_ONE;
        end else begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            a_prev_reg <= a_prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == G_MUL1) begin
            prod1_reg <= a_prev_reg * factor;
            recip_reg <= recip_tab[k_reg];
        end
        if (state_reg == G_RND1) begin
            t_reg <= sum1[P1W-1:15];
        end
        if (state_reg == G_MUL2) begin
            prod2_reg <= t_reg * $signed({1'b0, recip_reg});
        end
    end

    assign busy      = (state_reg != G_IDLE);
    assign coef_we   = (state_reg == G_RND2) && !start;
    assign coef_addr = k_reg;
    assign coef_data = a_sat;

endmodule

`default_nettype wire

### hw/rtl/plnsf_filter.sv
// Filter engine: coefficient memory, circular output-history memory and the
// multiply-accumulate pipeline with rounding and saturation. Uses plnsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plnsf_filter #(
    parameter int MAX_TAPS = plnsf_pkg::DEFAULT_MAX_TAPS
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 start,
    input  plnsf_pkg::white_t                   white,
    input  wire                                 blue,
    input  wire [$clog2(MAX_TAPS)-1:0]          last_k,
    input  wire                                 coef_we,
    input  wire [$clog2(MAX_TAPS)-1:0]          coef_addr,
    input  plnsf_pkg::coef_t                    coef_data,
    output logic                                idle,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output plnsf_pkg::noise_t                   m_noise_sample,
    output logic                                m_saturated
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int HIST  = MAX_TAPS - 1;
    localparam int PW    = plnsf_pkg::COEF_W + plnsf_pkg::NOISE_W;
    localparam int ACC_W = PW + AW + 1;
    localparam int RW    = ACC_W - 16;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(32768);
    localparam logic signed [RW-1:0]    Y_MAX = RW'(8388607);
    localparam logic signed [RW-1:0]    Y_MIN = -RW'(8388608);

    plnsf_pkg::coef_t       coef_mem [MAX_TAPS];
    plnsf_pkg::noise_t      hist_mem [HIST];

    logic [2:0]             state_reg, state_next;
    logic [AW-1:0]          k_reg;
    logic [AW-1:0]          last_k_reg;
    logic [AW-1:0]          rptr_reg;
    logic [AW-1:0]          wptr_reg;
    logic [AW-1:0]          fill_reg;
    logic                   v1_reg, m1_reg, v2_reg;
    plnsf_pkg::coef_t       coef_q_reg;
    plnsf_pkg::noise_t      hist_q_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [RW-1:0]   y_rnd_reg;
    plnsf_pkg::white_t      prev_white_reg;
    logic                   m_valid_reg;
    plnsf_pkg::noise_t      m_noise_reg;
    logic                   m_sat_reg;

    logic                   out_fire;
    logic signed [16:0]     s_val;
    logic signed [ACC_W-1:0] acc_neg;
    logic signed [ACC_W-1:0] acc_sum;
    logic [AW-1:0]          newest_ptr;
    plnsf_pkg::noise_t      y_sat;
    logic                   sat_flag;

    always_comb begin
        out_fire   = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
        s_val      = blue ? ({prev_white_reg[15], prev_white_reg} - {white[15], white})
                          : {white[15], white};
        acc_neg    = ACC_W'(acc_reg[ACC_W-1]);
        acc_sum    = acc_reg + HALF - acc_neg;
        newest_ptr = (wptr_reg == '0) ? AW'(HIST - 1) : wptr_reg - AW'(1);
        if (y_rnd_reg > Y_MAX) begin
            y_sat    = plnsf_pkg::NOISE_MAX;
            sat_flag = 1'b1;
        end else if (y_rnd_reg < Y_MIN) begin
            y_sat    = plnsf_pkg::NOISE_MIN;
            sat_flag = 1'b1;
        end else begin
            y_sat    = y_rnd_reg[plnsf_pkg::NOISE_W-1:0];
            sat_flag = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = ST_RUN;
            ST_RUN:   if (k_reg == last_k_reg) state_next = ST_DRAIN;
            ST_DRAIN: if (!v1_reg && !v2_reg) state_next = ST_ROUND;
            ST_ROUND: state_next = ST_OUT;
            ST_OUT:   if (out_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state. Reads and the history write never overlap because an
    // item runs alone. The coefficient memory is to be rewritten only while the
    // engine is held idle; the user is bound by this, the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wptr_reg       <= '0;
            fill_reg       <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
            prev_white_reg <= '0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == ST_RUN);
            v2_reg    <= v1_reg;
            if (state_reg == ST_IDLE && start) begin
                prev_white_reg <= white;
            end
            if (out_fire) begin
                wptr_reg <= (wptr_reg == AW'(HIST - 1)) ? '0 : wptr_reg + AW'(1);
                if (fill_reg != AW'(HIST)) begin
                    fill_reg <= fill_reg + AW'(1);
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && start) begin
            k_reg      <= AW'(1);
            last_k_reg <= last_k;
            rptr_reg   <= newest_ptr;
            acc_reg    <= {{(ACC_W - 33){s_val[16]}}, s_val, 16'b0};
        end
        if (state_reg == ST_RUN) begin
            m1_reg   <= (k_reg <= fill_reg);
            k_reg    <= k_reg + AW'(1);
            rptr_reg <= (rptr_reg == '0) ? AW'(HIST - 1) : rptr_reg - AW'(1);
        end
        if (v1_reg) begin
            if (m1_reg) begin
                prod_reg <= coef_q_reg * hist_q_reg;
            end else begin
                prod_reg <= '0;
            end
        end
        if (v2_reg) begin
            acc_reg <= acc_reg - {{(ACC_W - PW){prod_reg[PW-1]}}, prod_reg};
        end
        if (state_reg == ST_ROUND) begin
            y_rnd_reg <= acc_sum[ACC_W-1:16];
        end
        if (out_fire) begin
            m_noise_reg <= y_sat;
            m_sat_reg   <= sat_flag;
        end
    end

    // Memories.
    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[coef_addr] <= coef_data;
        end
        if (state_reg == ST_RUN) begin
            coef_q_reg <= coef_mem[k_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_fire) begin
            hist_mem[wptr_reg] <= y_sat;
        end
        if (state_reg == ST_RUN) begin
            hist_q_reg <= hist_mem[rptr_reg];
        end
    end

    assign idle           = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_noise_sample = m_noise_reg;
    assign m_saturated    = m_sat_reg;

    a_pipe_step: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |=> v2_reg)
        else $error("product stage did not follow read stage");

    a_round_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> (!v1_reg && !v2_reg))
        else $error("rounding started with products still in flight");

    a_tap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> ((k_reg != '0) && (k_reg <= last_k_reg)))
        else $error("tap index out of range");

    a_hist_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg <= AW'(HIST)) && (wptr_reg < AW'(HIST)))
        else $error("history pointer or fill count out of range");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire |=> (m_valid_reg && (state_reg == ST_IDLE)))
        else $error("finished sample not presented");

endmodule

`default_nettype wire
